// ===== src/ttcw_pkg.sv =====
// ttcw_pkg: shared types and constants for the time to collision warning block.
// No dependencies; used by ttcw_cfg, ttcw_div and time_to_collision_warning.
package ttcw_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT = 3'd4;

    // field widths
    localparam int RANGE_W = 16;
    localparam int SPEED_W = 32;
    localparam int TTC_W = 25;
    localparam int INTERVAL_W = 20;
    localparam int LIMIT_W = 16;
    localparam int WEIGHT_W = 8;

    // shared divider: |delta| * 1e6 needs 36 bits, -speed needs 32
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 32;

    localparam logic [INTERVAL_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [TTC_W-1:0] FAR_MS = 25'd9999000;
    localparam logic [TTC_W-1:0] TTC_MIN = 25'h1000000;  // -2^24

    // warning levels
    localparam logic [1:0] LVL_SAFE = 2'd0;
    localparam logic [1:0] LVL_WARNING = 2'd1;
    localparam logic [1:0] LVL_DANGER = 2'd2;
    localparam logic [1:0] LVL_ERROR = 2'd3;

    typedef struct packed {
        logic [WEIGHT_W-1:0] filter_weight;
        logic [INTERVAL_W-1:0] min_interval_us;
        logic [INTERVAL_W-1:0] max_interval_us;
        logic [LIMIT_W-1:0] danger_limit_ms;
        logic [LIMIT_W-1:0] warning_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [DIV_NUM_W-1:0] quot;
        logic rem_nz;
    } t_div_rsp;

endpackage

// ===== src/ttcw_cfg.sv =====
// ttcw_cfg: configuration register file, written one word per handshake.
// Depends on ttcw_pkg.
module ttcw_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_valid,
    input  logic [ttcw_pkg::CFG_IDX_W-1:0]      i_wr_index,
    input  logic [ttcw_pkg::CFG_DATA_W-1:0]     i_wr_data,
    output ttcw_pkg::t_cfg                      o_cfg
);

    ttcw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_weight    <= 8'd102;
            r_cfg.min_interval_us  <= 20'd20000;
            r_cfg.max_interval_us  <= 20'd300000;
            r_cfg.danger_limit_ms  <= 16'd1000;
            r_cfg.warning_limit_ms <= 16'd3000;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                ttcw_pkg::CFG_FILTER_WEIGHT: begin
                    r_cfg.filter_weight <= i_wr_data[ttcw_pkg::WEIGHT_W-1:0];
                end
                ttcw_pkg::CFG_MIN_INTERVAL: begin
                    r_cfg.min_interval_us <= i_wr_data;
                end
                ttcw_pkg::CFG_MAX_INTERVAL: begin
                    r_cfg.max_interval_us <= i_wr_data;
                end
                ttcw_pkg::CFG_DANGER_LIMIT: begin
                    r_cfg.danger_limit_ms <= i_wr_data[ttcw_pkg::LIMIT_W-1:0];
                end
                ttcw_pkg::CFG_WARNING_LIMIT: begin
                    r_cfg.warning_limit_ms <= i_wr_data[ttcw_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/ttcw_div.sv =====
// ttcw_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on ttcw_pkg (request/response structs and widths).
module ttcw_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ttcw_pkg::t_div_req  i_req,
    output ttcw_pkg::t_div_rsp  o_rsp
);

    localparam int NW = ttcw_pkg::DIV_NUM_W;
    localparam int DW = ttcw_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;   // dividend shifts out, quotient shifts in
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic [DW:0] n_trial;
    logic [DW:0] n_diff;
    logic        n_ge;

    always_comb begin
        n_trial = {r_rem, r_num[NW-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse after the last quotient bit
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_num;
    assign o_rsp.rem_nz = |r_rem;

endmodule

// ===== src/time_to_collision_warning.sv =====
// time_to_collision_warning: forward collision warning from timestamped range words.
// Depends on ttcw_pkg, ttcw_cfg (register file) and ttcw_div (shared divider).
//
// Each input word carries a free-running microsecond timestamp and a signed range in
// 1/16 cm (negative marks a sensor fault); each produces exactly one output word with
// the warning level, the time to collision in ms and the filtered closing speed in
// 1/16 cm/s. The first word after reset only latches time and range and reports safe
// with the far value 9999000 ms. Later words clamp the interval to the configured
// min/max (upper clamp wins, zero becomes 1 us), divide delta range * 1e6 by it,
// smooth the result with weight filter_weight/256, and, when the object approaches,
// divide range * 1000 by the negated speed. Both divisions go through one shared
// 36-step restoring divider, which sets the throughput: a normal word holds the input
// stalled until its result enters the output register. The first word, and a
// word whose filtered speed is not negative, skips one or both divisions. A finished
// result sits in the output register, so the next word is accepted and worked on
// while the downstream side stalls. Config writes are always ready and take effect
// at once; write them only while the block is idle.
module time_to_collision_warning #(
    parameter int TIMESTAMP_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [TIMESTAMP_WIDTH-1:0]           i_sample_time_us,
    input  logic signed [ttcw_pkg::RANGE_W-1:0]  i_range_sixteenths,
    // output words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_warn_level,
    output logic signed [ttcw_pkg::TTC_W-1:0]    o_collision_time_ms,
    output logic signed [ttcw_pkg::SPEED_W-1:0]  o_closing_speed,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ttcw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ttcw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int TW = TIMESTAMP_WIDTH;
    // compare width for the interval clamp: wide enough for both timestamp and limits
    localparam int CW = (TW > ttcw_pkg::INTERVAL_W) ? TW : ttcw_pkg::INTERVAL_W;
    localparam int RAW_W = ttcw_pkg::DIV_NUM_W + 1;  // signed raw speed
    localparam int ACC_W = 48;                       // filter accumulator
    localparam int PROD_W = 26;                      // range * 1000

    typedef enum logic [3:0] {
        S_IDLE,
        S_DT,
        S_DIV_SPEED,
        S_FILT_NEW,
        S_FILT_OLD,
        S_FILT_SAT,
        S_TTC,
        S_DIV_TTC,
        S_OUT
    } t_state;

    t_state r_state;

    ttcw_pkg::t_cfg     w_cfg;
    ttcw_pkg::t_div_req r_div_req;
    ttcw_pkg::t_div_rsp w_div_rsp;

    // --- state ---
    logic                               r_seen;
    logic [TW-1:0]                      r_prev_time;
    logic signed [ttcw_pkg::RANGE_W-1:0] r_prev_range;
    logic signed [ttcw_pkg::SPEED_W-1:0] r_speed;

    // --- per-word work registers ---
    logic [TW-1:0]                      r_diff;
    logic signed [ttcw_pkg::RANGE_W-1:0] r_range;
    logic signed [ttcw_pkg::RANGE_W:0]  r_delta;
    logic                               r_neg;
    logic signed [RAW_W-1:0]            r_raw;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [ttcw_pkg::TTC_W-1:0]  r_ttc;

    // --- output register ---
    logic                               r_out_valid;
    logic [1:0]                         r_warn_level;
    logic signed [ttcw_pkg::TTC_W-1:0]  r_collision_time;
    logic signed [ttcw_pkg::SPEED_W-1:0] r_closing_speed;

    // --- combinational helpers ---
    logic [CW-1:0]                      n_dt_ext;
    logic [CW-1:0]                      n_dt_lo;
    logic [CW-1:0]                      n_dt_hi;
    logic [ttcw_pkg::INTERVAL_W-1:0]    n_dt;
    logic [ttcw_pkg::RANGE_W-1:0]       n_delta_mag;
    logic [ttcw_pkg::DIV_NUM_W-1:0]     n_delta_scaled;
    logic signed [ACC_W-1:0]            n_new_term;
    logic signed [ACC_W-1:0]            n_old_term;
    logic [8:0]                         n_old_weight;
    logic signed [ACC_W-9:0]            n_filt_shift;
    logic signed [ttcw_pkg::SPEED_W-1:0] n_filt_sat;
    logic signed [PROD_W-1:0]           n_range_ms;
    logic [PROD_W-1:0]                  n_range_ms_mag;
    logic [ttcw_pkg::DIV_DEN_W-1:0]     n_speed_mag;
    logic [ttcw_pkg::TTC_W+1:0]         n_ceil_mag;
    logic signed [ttcw_pkg::TTC_W-1:0]  n_ttc;
    logic [1:0]                         n_level;
    logic                               n_out_free;

    ttcw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ttcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        // interval clamp: raise to min first, then cut to max, zero becomes 1 us
        n_dt_ext = CW'(r_diff);
        n_dt_lo  = (n_dt_ext < CW'(w_cfg.min_interval_us)) ?
                   CW'(w_cfg.min_interval_us) : n_dt_ext;
        n_dt_hi  = (n_dt_lo > CW'(w_cfg.max_interval_us)) ?
                   CW'(w_cfg.max_interval_us) : n_dt_lo;
        n_dt     = (n_dt_hi == '0) ? ttcw_pkg::INTERVAL_W'(1) :
                   n_dt_hi[ttcw_pkg::INTERVAL_W-1:0];

        // |delta| * 1e6, at most 65535e6 < 2^36
        n_delta_mag    = r_delta[ttcw_pkg::RANGE_W] ?
                         ttcw_pkg::RANGE_W'(-r_delta) : r_delta[ttcw_pkg::RANGE_W-1:0];
        n_delta_scaled = ttcw_pkg::DIV_NUM_W'(n_delta_mag) *
                         ttcw_pkg::DIV_NUM_W'(ttcw_pkg::US_PER_S);

        // exponential filter terms
        n_new_term   = r_raw * $signed({1'b0, w_cfg.filter_weight});
        n_old_weight = 9'd256 - {1'b0, w_cfg.filter_weight};
        n_old_term   = r_speed * $signed({1'b0, n_old_weight});

        // floor divide by 256, then saturate to 32 bits
        n_filt_shift = r_acc[ACC_W-1:8];
        if (n_filt_shift > $signed((ACC_W-8)'(32'h7FFF_FFFF))) begin
            n_filt_sat = 32'sh7FFF_FFFF;
        end else if (n_filt_shift < -$signed((ACC_W-8)'(33'h1_0000_0000) >>> 1)) begin
            n_filt_sat = 32'sh8000_0000;
        end else begin
            n_filt_sat = n_filt_shift[ttcw_pkg::SPEED_W-1:0];
        end

        // time to collision operands
        n_range_ms     = r_range * $signed(11'sd1000);
        n_range_ms_mag = n_range_ms[PROD_W-1] ? -n_range_ms : n_range_ms;
        n_speed_mag    = ~r_speed + 1'b1;  // -speed, 2^31 fits unsigned

        // floor rounding for negative times: magnitude rounds up
        n_ceil_mag = w_div_rsp.quot[ttcw_pkg::TTC_W+1:0] +
                     (ttcw_pkg::TTC_W+2)'(w_div_rsp.rem_nz);
        if (r_neg) begin
            if (n_ceil_mag > (ttcw_pkg::TTC_W+2)'(ttcw_pkg::TTC_MIN)) begin
                n_ttc = ttcw_pkg::TTC_MIN;
            end else begin
                n_ttc = -$signed(n_ceil_mag[ttcw_pkg::TTC_W-1:0]);
            end
        end else if (w_div_rsp.quot > ttcw_pkg::DIV_NUM_W'(ttcw_pkg::FAR_MS)) begin
            n_ttc = ttcw_pkg::FAR_MS;
        end else begin
            n_ttc = w_div_rsp.quot[ttcw_pkg::TTC_W-1:0];
        end

        // danger is checked ahead of warning
        if (r_ttc[ttcw_pkg::TTC_W-1]) begin
            n_level = ttcw_pkg::LVL_ERROR;
        end else if (r_ttc[ttcw_pkg::TTC_W-2:0] <
                     (ttcw_pkg::TTC_W-1)'(w_cfg.danger_limit_ms)) begin
            n_level = ttcw_pkg::LVL_DANGER;
        end else if (r_ttc[ttcw_pkg::TTC_W-2:0] <
                     (ttcw_pkg::TTC_W-1)'(w_cfg.warning_limit_ms)) begin
            n_level = ttcw_pkg::LVL_WARNING;
        end else begin
            n_level = ttcw_pkg::LVL_SAFE;
        end

        n_out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_seen          <= 1'b0;
            r_prev_time     <= '0;
            r_prev_range    <= '0;
            r_speed         <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            // divider kicks off from the interval step, and from the time step when approaching
            r_div_req.start <= (r_state == S_DT) ||
                               ((r_state == S_TTC) && r_speed[ttcw_pkg::SPEED_W-1]);
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_range      <= i_range_sixteenths;
                        r_diff       <= i_sample_time_us - r_prev_time;
                        r_delta      <= (ttcw_pkg::RANGE_W+1)'(i_range_sixteenths) -
                                        (ttcw_pkg::RANGE_W+1)'(r_prev_range);
                        r_prev_time  <= i_sample_time_us;
                        r_prev_range <= i_range_sixteenths;
                        if (r_seen) begin
                            r_state <= S_DT;
                        end else begin
                            // first word: no speed yet
                            r_seen  <= 1'b1;
                            r_speed <= '0;
                            r_state <= S_TTC;
                        end
                    end
                end
                S_DT: begin
                    r_neg           <= r_delta[ttcw_pkg::RANGE_W];
                    r_div_req.num   <= n_delta_scaled;
                    r_div_req.den   <= ttcw_pkg::DIV_DEN_W'(n_dt);
                    r_state         <= S_DIV_SPEED;
                end
                S_DIV_SPEED: begin
                    if (w_div_rsp.done) begin
                        // quotient truncates toward zero, sign reapplied
                        r_raw   <= r_neg ? -$signed({1'b0, w_div_rsp.quot}) :
                                           $signed({1'b0, w_div_rsp.quot});
                        r_state <= S_FILT_NEW;
                    end
                end
                S_FILT_NEW: begin
                    r_acc   <= n_new_term;
                    r_state <= S_FILT_OLD;
                end
                S_FILT_OLD: begin
                    r_acc   <= r_acc + n_old_term;
                    r_state <= S_FILT_SAT;
                end
                S_FILT_SAT: begin
                    r_speed <= n_filt_sat;
                    r_state <= S_TTC;
                end
                S_TTC: begin
                    if (!r_speed[ttcw_pkg::SPEED_W-1]) begin
                        // not approaching
                        r_ttc   <= ttcw_pkg::FAR_MS;
                        r_state <= S_OUT;
                    end else begin
                        r_neg           <= n_range_ms[PROD_W-1];
                        r_div_req.num   <= ttcw_pkg::DIV_NUM_W'(n_range_ms_mag);
                        r_div_req.den   <= n_speed_mag;
                        r_state         <= S_DIV_TTC;
                    end
                end
                S_DIV_TTC: begin
                    if (w_div_rsp.done) begin
                        r_ttc   <= n_ttc;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_warn_level     <= n_level;
                        r_collision_time <= r_ttc;
                        r_closing_speed  <= r_speed;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_warn_level        = r_warn_level;
    assign o_collision_time_ms = r_collision_time;
    assign o_closing_speed     = r_closing_speed;
    assign o_cfg_ready         = 1'b1;

endmodule

// ===== tb/tb_time_to_collision_warning.sv =====
// tb_time_to_collision_warning: self-checking testbench for the collision warning block.
// Depends on ttcw_pkg and time_to_collision_warning; predicts every output word and
// compares it field by field under random input gaps and output stalls.
module tb_time_to_collision_warning;
    timeunit 1ns;
    timeprecision 1ps;

    import ttcw_pkg::*;

    // ---------------------------------------------------------------
    // constants
    // ---------------------------------------------------------------
    localparam int     RESET_CYCLES   = 12;
    localparam int     QUIET_LIMIT    = 4000;   // cycles with no handshake at all
    localparam int     HOLD_CYCLES    = 500;    // long downstream hold-off
    localparam int     TAIL_CYCLES    = 200;    // settle time after the last word
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_ITEMS    = 240;
    localparam longint TTC_FLOOR_MS   = -64'sd16777216;
    localparam longint SPEED_MAX      = 64'sd2147483647;
    localparam longint SPEED_MIN      = -64'sd2147483648;
    // index outside the register map; the write must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    // downstream stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_RUNS,
        STALL_SPARSE
    } stall_mode_e;

    // one predicted output word
    typedef struct {
        logic [1:0]         level;
        logic signed [24:0] ttc_ms;
        logic signed [31:0] speed;
    } warning_t;

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                       i_clk;
    logic                       i_rst_n            = 1'b0;
    logic                       i_in_valid         = 1'b0;
    logic                       o_in_stall;
    logic [31:0]                i_sample_time_us   = '0;
    logic signed [RANGE_W-1:0]  i_range_sixteenths = '0;
    logic                       o_out_valid;
    logic                       i_out_stall        = 1'b0;
    logic [1:0]                 o_warn_level;
    logic signed [TTC_W-1:0]    o_collision_time_ms;
    logic signed [SPEED_W-1:0]  o_closing_speed;
    logic                       i_cfg_valid        = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data         = '0;

    time_to_collision_warning #(
        .TIMESTAMP_WIDTH(32)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample_time_us    (i_sample_time_us),
        .i_range_sixteenths  (i_range_sixteenths),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_warn_level        (o_warn_level),
        .o_collision_time_ms (o_collision_time_ms),
        .o_closing_speed     (o_closing_speed),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // tracker shadow: registers plus the block's running state
    // ---------------------------------------------------------------
    t_cfg               shadow_cfg = '{8'd102, 20'd20000, 20'd300000, 16'd1000, 16'd3000};
    logic               trk_seen       = 1'b0;
    logic [31:0]        trk_prev_time  = '0;
    logic signed [15:0] trk_prev_range = '0;
    logic signed [31:0] trk_speed      = '0;

    warning_t pending_warnings[$];

    int error_count      = 0;
    int samples_sent     = 0;
    int warnings_checked = 0;
    int settings_applied = 0;
    int burst_left       = 0;
    bit sender_idles     = 1'b0;
    int hold_requests    = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic longint floor_quot(input longint num, input longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // advance the shadow tracker by one accepted word and queue its warning
    task automatic predict_warning(input logic [31:0] stamp, input logic signed [15:0] rng);
        logic [31:0] elapsed;
        longint      dt, r64, p64, sp64, delta, raw, acc, w, ttc;
        warning_t    res;
        r64 = rng;
        if (!trk_seen) begin
            // first word only latches; speed starts at zero
            trk_seen  = 1'b1;
            trk_speed = '0;
        end else begin
            elapsed = stamp - trk_prev_time;     // modulo 2^32
            dt = elapsed;
            if (dt < shadow_cfg.min_interval_us) dt = shadow_cfg.min_interval_us;
            if (dt > shadow_cfg.max_interval_us) dt = shadow_cfg.max_interval_us;
            if (dt == 0) dt = 1;
            p64   = trk_prev_range;
            delta = r64 - p64;
            raw   = (delta * 64'sd1000000) / dt;   // truncates toward zero
            w     = shadow_cfg.filter_weight;
            sp64  = trk_speed;
            acc   = w * raw + (256 - w) * sp64;
            acc   = acc >>> 8;                     // floor
            if (acc > SPEED_MAX) acc = SPEED_MAX;
            if (acc < SPEED_MIN) acc = SPEED_MIN;
            trk_speed = acc[31:0];
        end
        trk_prev_time  = stamp;
        trk_prev_range = rng;

        sp64 = trk_speed;
        if (sp64 >= 0) begin
            ttc = FAR_MS;                          // not approaching
        end else begin
            ttc = floor_quot(r64 * 1000, -sp64);
            if (ttc > longint'(FAR_MS)) ttc = FAR_MS;
            if (ttc < TTC_FLOOR_MS) ttc = TTC_FLOOR_MS;
        end

        // danger is tested before warning
        if (ttc < 0)                                res.level = LVL_ERROR;
        else if (ttc < shadow_cfg.danger_limit_ms)  res.level = LVL_DANGER;
        else if (ttc < shadow_cfg.warning_limit_ms) res.level = LVL_WARNING;
        else                                        res.level = LVL_SAFE;
        res.ttc_ms = ttc[24:0];
        res.speed  = trk_speed;
        pending_warnings.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // output side: check accepted words, then pick next stall value
    // ---------------------------------------------------------------
    stall_mode_e stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          run_left    = 0;
    bit          run_stalled = 1'b0;
    int          hold_left   = 0;
    int          hold_served = 0;

    always @(posedge i_clk) begin
        warning_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_warnings.size() == 0) begin
                $error("unexpected result word: level %0d ttc %0d speed %0d",
                       o_warn_level, o_collision_time_ms, o_closing_speed);
                error_count++;
            end else begin
                want = pending_warnings.pop_front();
                warnings_checked++;
                if (o_warn_level !== want.level) begin
                    $error("warn_level: expected %0d, actual %0d", want.level, o_warn_level);
                    error_count++;
                end
                if (o_collision_time_ms !== want.ttc_ms) begin
                    $error("collision_time_ms: expected %0d, actual %0d",
                           want.ttc_ms, o_collision_time_ms);
                    error_count++;
                end
                if (o_closing_speed !== want.speed) begin
                    $error("closing_speed: expected %0d, actual %0d",
                           want.speed, o_closing_speed);
                    error_count++;
                end
            end
        end

        // a pending hold-off request overrides the random pattern
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(50, 600);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_COIN:   i_out_stall <= ($urandom_range(0, 1) == 1);
                STALL_RUNS: begin
                    if (run_left == 0) begin
                        run_stalled = ~run_stalled;
                        run_left    = $urandom_range(1, 120);
                    end else begin
                        run_left--;
                    end
                    i_out_stall <= run_stalled;
                end
                default:      i_out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // watchdog: no handshake on any channel for too long ends the run
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    // offer one word and hold it until accepted; valid stays high afterward
    task automatic send_sample(input logic [31:0] stamp, input logic signed [15:0] rng);
        i_in_valid         <= 1'b1;
        i_sample_time_us   <= stamp;
        i_range_sixteenths <= rng;
        do @(posedge i_clk); while (o_in_stall);
        predict_warning(stamp, rng);
        samples_sent++;
    endtask

    // same, with bursts and random gaps in front when idling is on
    task automatic offer_sample(input logic [31:0] stamp, input logic signed [15:0] rng);
        int gap;
        if (sender_idles) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap        = $urandom_range(1, 100);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        send_sample(stamp, rng);
    endtask

    // block is idle once every queued warning is out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_warnings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; caller lowers it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FILTER_WEIGHT: shadow_cfg.filter_weight    = val[WEIGHT_W-1:0];
            CFG_MIN_INTERVAL:  shadow_cfg.min_interval_us  = val[INTERVAL_W-1:0];
            CFG_MAX_INTERVAL:  shadow_cfg.max_interval_us  = val[INTERVAL_W-1:0];
            CFG_DANGER_LIMIT:  shadow_cfg.danger_limit_ms  = val[LIMIT_W-1:0];
            CFG_WARNING_LIMIT: shadow_cfg.warning_limit_ms = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_cfg s);
        drain_results();
        write_register(CFG_FILTER_WEIGHT, CFG_DATA_W'(s.filter_weight));
        write_register(CFG_MIN_INTERVAL,  s.min_interval_us);
        write_register(CFG_MAX_INTERVAL,  s.max_interval_us);
        write_register(CFG_DANGER_LIMIT,  CFG_DATA_W'(s.danger_limit_ms));
        write_register(CFG_WARNING_LIMIT, CFG_DATA_W'(s.warning_limit_ms));
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [INTERVAL_W-1:0] pick_interval();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 20'd1;
            2:       return 20'hFFFFF;
            3:       return 20'd1000000;
            default: return INTERVAL_W'($urandom_range(1000, 400000));
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return LIMIT_W'($urandom_range(0, 8000));
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg s;
        case ($urandom_range(0, 3))
            0:       s.filter_weight = '0;
            1:       s.filter_weight = 8'hFF;
            default: s.filter_weight = WEIGHT_W'($urandom_range(1, 254));
        endcase
        s.min_interval_us  = pick_interval();
        s.max_interval_us  = pick_interval();
        s.danger_limit_ms  = pick_limit();
        s.warning_limit_ms = pick_limit();
        return s;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // reset defaults: first word, tracking, both clamps, wrap, zero and
    // negative range, receding object
    task automatic test_tracking_defaults();
        logic [31:0] stamp;
        stamp = 32'h8000_0000;
        send_sample(stamp, 16'sd1600);            // first word: safe, far
        stamp += 100000;  send_sample(stamp, 16'sd1500);
        stamp += 100000;  send_sample(stamp, 16'sd1300);
        stamp += 10;      send_sample(stamp, 16'sd1100);   // raised to min
        stamp += 5000000; send_sample(stamp, 16'sd900);    // cut to max
        send_sample(32'hFFFF_FFF0, 16'sd700);
        send_sample(32'h0000_C340, 16'sd500);     // timestamp wraps
        stamp = 32'h0000_C340 + 100000;
        send_sample(stamp, 16'sd0);               // zero range: danger
        stamp += 100000;  send_sample(stamp, -16'sd40);    // fault while closing
        stamp += 100000;  send_sample(stamp, 16'sd32767);  // receding
    endtask

    // speed and time saturation, zero interval, crossed clamps
    task automatic test_saturation();
        logic [31:0] stamp;
        stamp = $urandom;
        // both clamps zero: interval forced to 1 us, full-scale steps
        apply_settings('{8'hFF, 20'd0, 20'd0, 16'd1000, 16'd3000});
        send_sample(stamp, 16'sd32767);
        send_sample(stamp, -16'sd32768);          // speed pinned at minimum
        send_sample(stamp, 16'sd32767);           // speed pinned at maximum
        // min above max: upper clamp wins, interval 300 ms
        apply_settings('{8'hFF, 20'hFFFFF, 20'd300000, 16'd1000, 16'd3000});
        repeat (2) send_sample(stamp, 16'sd32767);        // speed decays
        send_sample(stamp, 16'sd32766);           // slow closing, speed still positive: far value
        send_sample(stamp, -16'sd32767);
        send_sample(stamp, -16'sd32768);
        repeat (2) send_sample(stamp, -16'sd32768);       // speed -1: time floor
    endtask

    // zero danger limit, and danger limit above warning limit
    task automatic test_thresholds();
        logic [31:0] stamp;
        stamp = $urandom;
        apply_settings('{8'hFF, 20'd1, 20'd1000000, 16'd0, 16'hFFFF});
        repeat (4) send_sample(stamp, 16'sd100);          // forget old speed
        stamp += 100000; send_sample(stamp, 16'sd0);      // time 0, not danger
        apply_settings('{8'hFF, 20'd1, 20'd1000000, 16'hFFFF, 16'd0});
        @(posedge i_clk);
        write_register(CFG_SPARE_INDEX, 20'hA5A5A);       // must be ignored
        i_cfg_valid <= 1'b0;
        stamp += 100000; send_sample(stamp, 16'sd500);
        stamp += 100000; send_sample(stamp, 16'sd400);    // danger wins
    endtask

    // random phases: mostly approach/recede tracks, some noise and
    // broken timing; one phase gets a long downstream hold-off
    task automatic test_random_traffic();
        logic [31:0]        stamp;
        logic signed [15:0] rng;
        int                 track, approach;
        stamp    = $urandom;
        track    = $urandom_range(200, 32767);
        approach = -$urandom_range(0, 600);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) apply_settings('{8'd102, 20'd20000, 20'd300000, 16'd1000, 16'd3000});
            else        apply_settings(random_settings());
            sender_idles = ($urandom_range(0, 3) != 0);
            burst_left   = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 40) hold_requests <= hold_requests + 1;
                case ($urandom_range(0, 9))
                    0: begin
                        // noise: any timestamp, any range
                        stamp = $urandom;
                        rng   = 16'($urandom);
                    end
                    1: begin
                        // burst of samples too close together
                        stamp += $urandom_range(0, 25000);
                        rng   = 16'(track + $signed($urandom_range(0, 200)) - 100);
                    end
                    default: begin
                        stamp += $urandom_range(1000, 350000);
                        track += approach + $signed($urandom_range(0, 40)) - 20;
                        if (track < -300 || track > 32767 || $urandom_range(0, 60) == 0) begin
                            track    = $urandom_range(200, 32767);
                            approach = ($urandom_range(0, 4) == 0) ?
                                       $urandom_range(0, 300) : -$urandom_range(0, 800);
                        end
                        if (track > 32767) track = 32767;
                        rng = 16'(track);
                    end
                endcase
                offer_sample(stamp, rng);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tracking_defaults();
        test_saturation();
        test_thresholds();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d range words and %0d register settings,", samples_sent,
                 settings_applied);
        $display("with %0d warning words checked under random gaps and stalls",
                 warnings_checked);
        if (error_count == 0 && pending_warnings.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
